[rtl/lkc_pkg.sv]
package lkc_pkg;

    localparam int ENTRIES_DEF = 4;
    localparam int KEY_W       = 64;
    localparam int STAMP_W     = 32;
    localparam int SLOT_W      = 2;
    localparam int OP_W        = 2 * KEY_W;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // operation of the shared comparator
    typedef enum logic [1:0] {
        CMP_EQ = 2'b01,
        CMP_LT = 2'b10
    } cmp_mode_t;

endpackage

[rtl/lkc_if.sv]
interface lkc_req_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [lkc_pkg::KEY_W-1:0]   key_high;
    logic [lkc_pkg::KEY_W-1:0]   key_low;
    logic [lkc_pkg::STAMP_W-1:0] now;

    modport source (output valid, output cmd, output key_high, output key_low, output now,
                    input ready);
    modport sink   (input valid, input cmd, input key_high, input key_low, input now,
                    output ready);
endinterface

interface lkc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [lkc_pkg::SLOT_W-1:0] slot;
    logic                       evicted;

    modport source (output valid, output hit, output slot, output evicted, input ready);
    modport sink   (input valid, input hit, input slot, input evicted, output ready);
endinterface

[rtl/lkc_ram.sv]
module lkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/lkc_cmp.sv]
module lkc_cmp (
    input  lkc_pkg::cmp_mode_t          mode,
    input  logic [lkc_pkg::OP_W-1:0]    a,
    input  logic [lkc_pkg::OP_W-1:0]    b,
    output logic                        res
);

    always_comb
    begin
        case (mode)
            lkc_pkg::CMP_EQ: res = (a == b);
            lkc_pkg::CMP_LT: res = (a[lkc_pkg::STAMP_W-1:0] < b[lkc_pkg::STAMP_W-1:0]);
            default:         res = 1'b0;
        endcase
    end

endmodule

[rtl/lru_key_cache.sv]
// Fully associative cache of 128-bit keys with least recently used replacement.
// req carries cmd (lookup or insert), the key halves and the current time; rsp
// carries hit, slot and evicted, one transfer per request, in request order.
// A lookup walks the filled entries one per cycle through a single comparator
// and stamps the first match with the time. An insert writes the next free slot,
// or once full walks all stamps with the same comparator to find the oldest.
// An insert with room and a lookup on an empty cache skip the walk. A lookup
// ends at its first match or after the last filled entry; an insert when full
// ends after the last entry.
// The walk is paced by the registered read port of the key and stamp RAMs.
// req.ready is high whenever no request is in progress, so a new request is
// taken the cycle after the previous result is registered, even while that
// result still waits on rsp. If the receiver stalls, a finished request holds
// in its last state until the output register frees up.
// Reset empties the cache (fill count zero) and clears the output valid flag;
// key and stamp RAM contents are not cleared and are never read before written.
module lru_key_cache #(
    parameter int ENTRIES = lkc_pkg::ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lkc_req_if.sink       req,
    lkc_rsp_if.source     rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                         state_reg;
    logic [CNT_W-1:0]               fill_reg;
    logic                           pend_reg;
    logic                           out_valid_reg;

    logic                           cmd_reg;
    logic [lkc_pkg::KEY_W-1:0]      kh_reg;
    logic [lkc_pkg::KEY_W-1:0]      kl_reg;
    logic [lkc_pkg::STAMP_W-1:0]    now_reg;
    logic [CNT_W-1:0]               limit_reg;
    logic [CNT_W-1:0]               rd_idx_reg;
    logic [IDX_W-1:0]               pend_idx_reg;
    logic [lkc_pkg::STAMP_W-1:0]    best_reg;
    logic [IDX_W-1:0]               best_idx_reg;
    logic [IDX_W-1:0]               tgt_reg;
    logic                           hit_reg;
    logic                           evict_reg;
    logic                           wr_reg;
    logic                           out_hit_reg;
    logic [lkc_pkg::SLOT_W-1:0]     out_slot_reg;
    logic                           out_evict_reg;

    logic                           accept;
    logic                           is_ins;
    logic                           full;
    logic                           issue;
    logic                           last;
    logic                           first;
    logic                           take;
    logic                           finish;
    logic [IDX_W-1:0]               raddr;
    logic [IDX_W-1:0]               new_best_idx;
    logic [lkc_pkg::STAMP_W-1:0]    new_best;
    logic [lkc_pkg::KEY_W-1:0]      kh_dout;
    logic [lkc_pkg::KEY_W-1:0]      kl_dout;
    logic [lkc_pkg::STAMP_W-1:0]    stamp_dout;
    lkc_pkg::cmp_mode_t             cmp_mode;
    logic [lkc_pkg::OP_W-1:0]       op_a;
    logic [lkc_pkg::OP_W-1:0]       op_b;
    logic                           cmp_res;
    logic                           we_key;
    logic                           we_stamp;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign is_ins    = (req.cmd == lkc_pkg::CMD_INSERT);
    assign full      = (fill_reg == CNT_W'(ENTRIES));
    assign issue     = (rd_idx_reg < limit_reg);
    assign raddr     = issue ? rd_idx_reg[IDX_W-1:0] : '0;
    assign last      = (CNT_W'(pend_idx_reg) == limit_reg - CNT_W'(1));
    assign first     = (pend_idx_reg == '0);
    assign finish    = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // one comparator: key equality on lookup, stamp less-than on replacement search
    assign cmp_mode = (cmd_reg == lkc_pkg::CMD_INSERT) ? lkc_pkg::CMP_LT : lkc_pkg::CMP_EQ;
    assign op_a = (cmd_reg == lkc_pkg::CMD_INSERT) ? lkc_pkg::OP_W'(stamp_dout)
                                                   : {kh_dout, kl_dout};
    assign op_b = (cmd_reg == lkc_pkg::CMD_INSERT) ? lkc_pkg::OP_W'(best_reg)
                                                   : {kh_reg, kl_reg};

    lkc_cmp u_cmp (
        .mode (cmp_mode),
        .a    (op_a),
        .b    (op_b),
        .res  (cmp_res)
    );

    // strict less-than keeps the lowest index on equal stamps
    assign take         = first || cmp_res;
    assign new_best_idx = take ? pend_idx_reg : best_idx_reg;
    assign new_best     = take ? stamp_dout : best_reg;

    assign we_key   = (state_reg == ST_DONE) && wr_reg && (cmd_reg == lkc_pkg::CMD_INSERT);
    assign we_stamp = (state_reg == ST_DONE) && wr_reg;

    lkc_ram #(.WIDTH(lkc_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_high_ram (
        .clk   (clk),
        .we    (we_key),
        .waddr (tgt_reg),
        .wdata (kh_reg),
        .raddr (raddr),
        .rdata (kh_dout)
    );

    lkc_ram #(.WIDTH(lkc_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_low_ram (
        .clk   (clk),
        .we    (we_key),
        .waddr (tgt_reg),
        .wdata (kl_reg),
        .raddr (raddr),
        .rdata (kl_dout)
    );

    lkc_ram #(.WIDTH(lkc_pkg::STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
        .clk   (clk),
        .we    (we_stamp),
        .waddr (tgt_reg),
        .wdata (now_reg),
        .raddr (raddr),
        .rdata (stamp_dout)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    pend_reg <= 1'b0;
                    if (accept)
                    begin
                        if (is_ins && !full)
                        begin
                            fill_reg  <= fill_reg + CNT_W'(1);
                            state_reg <= ST_DONE;
                        end
                        else if (!is_ins && (fill_reg == '0))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    pend_reg <= issue;
                    if (pend_reg && (last || (cmd_reg == lkc_pkg::CMD_LOOKUP && cmp_res)))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (finish)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg    <= req.cmd;
                    kh_reg     <= req.key_high;
                    kl_reg     <= req.key_low;
                    now_reg    <= req.now;
                    rd_idx_reg <= '0;
                    limit_reg  <= is_ins ? CNT_W'(ENTRIES) : fill_reg;
                    tgt_reg    <= is_ins ? IDX_W'(fill_reg) : '0;
                    hit_reg    <= 1'b0;
                    evict_reg  <= 1'b0;
                    wr_reg     <= is_ins;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                pend_idx_reg <= raddr;
                if (pend_reg)
                begin
                    if (cmd_reg == lkc_pkg::CMD_LOOKUP)
                    begin
                        if (cmp_res)
                        begin
                            hit_reg <= 1'b1;
                            tgt_reg <= pend_idx_reg;
                            wr_reg  <= 1'b1;
                        end
                    end
                    else
                    begin
                        best_reg     <= new_best;
                        best_idx_reg <= new_best_idx;
                        if (last)
                        begin
                            tgt_reg   <= new_best_idx;
                            evict_reg <= 1'b1;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    out_hit_reg   <= hit_reg;
                    out_slot_reg  <= lkc_pkg::SLOT_W'(tgt_reg);
                    out_evict_reg <= evict_reg;
                end
            end
            default:
            begin
                rd_idx_reg <= '0;
            end
        endcase
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.hit     = out_hit_reg;
    assign rsp.slot    = out_slot_reg;
    assign rsp.evicted = out_evict_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond capacity");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.evicted))
        else $error("result flags both hit and eviction");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.evicted) |-> full)
        else $error("eviction reported while cache not full");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_ins && !full) |=> (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("insert with room did not advance fill count");
`endif

endmodule

[sim/lru_key_cache_test.sv]
module lru_key_cache_test;

    localparam int N_RANDOM  = 1130;
    localparam int POOL      = 8;
    localparam int MAX_SHOWN = 10;
    localparam int DRAIN     = 20;

    localparam logic LKP = lkc_pkg::CMD_LOOKUP;
    localparam logic INS = lkc_pkg::CMD_INSERT;

    localparam logic [lkc_pkg::KEY_W-1:0]   K_ZERO = '0;
    localparam logic [lkc_pkg::KEY_W-1:0]   K_ONES = '1;
    localparam logic [lkc_pkg::KEY_W-1:0]   K_A_HI = 64'h0123_4567_89AB_CDEF;
    localparam logic [lkc_pkg::KEY_W-1:0]   K_A_LO = 64'hFEDC_BA98_7654_3210;
    localparam logic [lkc_pkg::KEY_W-1:0]   K_B_HI = 64'h8000_0000_0000_0000;
    localparam logic [lkc_pkg::KEY_W-1:0]   K_B_LO = 64'h0000_0000_0000_0001;
    localparam logic [lkc_pkg::KEY_W-1:0]   K_D_HI = 64'h5555_5555_5555_5555;
    localparam logic [lkc_pkg::KEY_W-1:0]   K_D_LO = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [lkc_pkg::STAMP_W-1:0] T_MAX  = '1;

    typedef struct packed {
        logic                        cmd;
        logic [lkc_pkg::KEY_W-1:0]   key_high;
        logic [lkc_pkg::KEY_W-1:0]   key_low;
        logic [lkc_pkg::STAMP_W-1:0] now;
    } cache_req_t;

    typedef struct packed {
        logic                       hit;
        logic [lkc_pkg::SLOT_W-1:0] slot;
        logic                       evicted;
    } cache_rsp_t;

    // is_typed: the expected result is written into the table, not predicted
    typedef struct packed {
        logic       is_typed;
        cache_rsp_t rsp;
    } typed_rsp_t;

    typedef struct packed {
        cache_req_t req;
        typed_rsp_t exp;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lkc_req_if req_ch ();
    lkc_rsp_if rsp_ch ();

    lru_key_cache i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    // shadow copy of the cache contents
    logic [lkc_pkg::KEY_W-1:0]   tag_hi   [lkc_pkg::ENTRIES_DEF];
    logic [lkc_pkg::KEY_W-1:0]   tag_lo   [lkc_pkg::ENTRIES_DEF];
    logic [lkc_pkg::STAMP_W-1:0] stamp_of [lkc_pkg::ENTRIES_DEF];
    int                          fill_cnt;

    cache_rsp_t expected_rsp_q [$];
    typed_rsp_t typed_q [$];

    int   err_cnt   = 0;
    int   n_checked = 0;
    int   n_lookup  = 0;
    int   n_hit     = 0;
    int   n_insert  = 0;
    int   n_evict   = 0;
    logic no_idle   = 1'b0;

    function automatic cache_rsp_t cache_apply(input cache_req_t r);
        cache_rsp_t o;
        int         i;
        int         v;
        logic       found;
        o.hit     = 1'b0;
        o.slot    = '0;
        o.evicted = 1'b0;
        found     = 1'b0;
        if (r.cmd == lkc_pkg::CMD_LOOKUP)
        begin
            for (i = 0; i < fill_cnt; i++)
            begin
                if (!found && tag_hi[i] == r.key_high && tag_lo[i] == r.key_low)
                begin
                    found       = 1'b1;
                    stamp_of[i] = r.now;
                    o.hit       = 1'b1;
                    o.slot      = i[lkc_pkg::SLOT_W-1:0];
                end
            end
        end
        else
        begin
            if (fill_cnt < lkc_pkg::ENTRIES_DEF)
            begin
                v = fill_cnt;
                fill_cnt++;
            end
            else
            begin
                // oldest stamp, lowest index on a tie
                v = 0;
                for (i = 1; i < lkc_pkg::ENTRIES_DEF; i++)
                begin
                    if (stamp_of[i] < stamp_of[v])
                        v = i;
                end
                o.evicted = 1'b1;
            end
            tag_hi[v]   = r.key_high;
            tag_lo[v]   = r.key_low;
            stamp_of[v] = r.now;
            o.slot      = v[lkc_pkg::SLOT_W-1:0];
        end
        return o;
    endfunction

    function automatic dir_row_t mk_row(input logic cmd,
                                        input logic [lkc_pkg::KEY_W-1:0] kh,
                                        input logic [lkc_pkg::KEY_W-1:0] kl,
                                        input logic [lkc_pkg::STAMP_W-1:0] t,
                                        input logic is_typed,
                                        input logic h, input logic [lkc_pkg::SLOT_W-1:0] s,
                                        input logic e);
        dir_row_t d;
        d.req.cmd         = cmd;
        d.req.key_high    = kh;
        d.req.key_low     = kl;
        d.req.now         = t;
        d.exp.is_typed    = is_typed;
        d.exp.rsp.hit     = h;
        d.exp.rsp.slot    = s;
        d.exp.rsp.evicted = e;
        return d;
    endfunction

    task automatic send_item(input cache_req_t r, input typed_rsp_t t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        typed_q.push_back(t);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= r.cmd;
        req_ch.key_high <= r.key_high;
        req_ch.key_low  <= r.key_low;
        req_ch.now      <= r.now;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // predict on every request transfer; the shadow copy empties with the reset
    always @(posedge clk)
    begin : req_mon
        cache_req_t r;
        cache_rsp_t p;
        typed_rsp_t t;
        int         k;
        if (!rst_n)
        begin
            fill_cnt = 0;
            for (k = 0; k < lkc_pkg::ENTRIES_DEF; k++)
            begin
                tag_hi[k]   = '0;
                tag_lo[k]   = '0;
                stamp_of[k] = '0;
            end
        end
        else if (req_ch.valid && req_ch.ready)
        begin
            r.cmd      = req_ch.cmd;
            r.key_high = req_ch.key_high;
            r.key_low  = req_ch.key_low;
            r.now      = req_ch.now;
            p = cache_apply(r);
            t = typed_q.pop_front();
            expected_rsp_q.push_back(t.is_typed ? t.rsp : p);
            if (r.cmd == lkc_pkg::CMD_LOOKUP)
            begin
                n_lookup++;
                n_hit += p.hit;
            end
            else
            begin
                n_insert++;
                n_evict += p.evicted;
            end
        end
    end

    always @(posedge clk)
    begin : rsp_mon
        cache_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_SHOWN)
                    $display("%0t: result with nothing pending: hit=%0d slot=%0d evicted=%0d",
                             $realtime, rsp_ch.hit, rsp_ch.slot, rsp_ch.evicted);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                n_checked++;
                if (rsp_ch.hit !== want.hit || rsp_ch.slot !== want.slot
                    || rsp_ch.evicted !== want.evicted)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN)
                        $display("%0t: result %0d exp hit=%0d slot=%0d evicted=%0d, got %0d %0d %0d",
                                 $realtime, n_checked, want.hit, want.slot, want.evicted,
                                 rsp_ch.hit, rsp_ch.slot, rsp_ch.evicted);
                end
            end
        end
    end

    // receiver: random stall ahead of each result, none while no_idle is set
    initial
    begin : rsp_side
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin : watchdog
        #2000000;
        $display("timeout with %0d results outstanding", expected_rsp_q.size());
        $display("[lru_key_cache] ERROR");
        $finish;
    end

    initial
    begin : stim
        dir_row_t                    dir [$];
        cache_req_t                  r;
        typed_rsp_t                  none;
        logic [lkc_pkg::KEY_W-1:0]   pool_hi [POOL];
        logic [lkc_pkg::KEY_W-1:0]   pool_lo [POOL];
        logic [lkc_pkg::STAMP_W-1:0] tnow;
        int                          n;
        int                          p;
        int                          kind;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = lkc_pkg::CMD_LOOKUP;
        req_ch.key_high = '0;
        req_ch.key_low  = '0;
        req_ch.now      = '0;
        none = '0;

        // empty cache, extremes, fill, touch, duplicate key, LRU eviction with ties
        dir.push_back(mk_row(LKP, K_ZERO, K_ZERO, '0,     1'b1, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(LKP, K_ONES, K_ONES, T_MAX,  1'b1, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(INS, K_ONES, K_ONES, '0,     1'b1, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(INS, K_ZERO, K_ZERO, T_MAX,  1'b1, 1'b0, 2'd1, 1'b0));
        dir.push_back(mk_row(LKP, K_ZERO, K_ZERO, 32'd5,  1'b1, 1'b1, 2'd1, 1'b0));
        dir.push_back(mk_row(LKP, K_ONES, K_ONES, 32'd7,  1'b1, 1'b1, 2'd0, 1'b0));
        dir.push_back(mk_row(INS, K_A_HI, K_A_LO, 32'd10, 1'b1, 1'b0, 2'd2, 1'b0));
        dir.push_back(mk_row(INS, K_A_HI, K_A_LO, 32'd10, 1'b1, 1'b0, 2'd3, 1'b0));
        dir.push_back(mk_row(LKP, K_A_HI, K_A_LO, 32'd20, 1'b1, 1'b1, 2'd2, 1'b0));
        dir.push_back(mk_row(INS, K_B_HI, K_B_LO, 32'd30, 1'b1, 1'b0, 2'd1, 1'b1));
        dir.push_back(mk_row(LKP, K_ZERO, K_ZERO, 32'd31, 1'b1, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(LKP, K_ONES, K_ZERO, 32'd32, 1'b0, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(LKP, K_A_HI, K_A_LO, 32'd7,  1'b0, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(INS, K_B_LO, K_B_HI, 32'd40, 1'b0, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(INS, K_D_HI, K_D_LO, 32'd50, 1'b0, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(LKP, K_A_HI, K_A_LO, T_MAX,  1'b0, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(INS, K_D_LO, K_D_HI, '0,     1'b0, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(INS, K_ZERO, K_ONES, '0,     1'b0, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(LKP, K_D_LO, K_D_HI, 32'd60, 1'b0, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(LKP, K_ZERO, K_ONES, 32'd61, 1'b0, 1'b0, 2'd0, 1'b0));
        dir.push_back(mk_row(LKP, K_A_HI, K_ZERO, 32'd62, 1'b0, 1'b0, 2'd0, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < dir.size(); n++)
            send_item(dir[n].req, dir[n].exp);

        // random part: keys mostly from a small pool so lookups hit and evictions happen
        for (p = 0; p < POOL; p++)
        begin
            pool_hi[p] = {$urandom, $urandom};
            pool_lo[p] = {$urandom, $urandom};
        end
        tnow = 32'd100;
        for (n = 0; n < N_RANDOM; n++)
        begin
            if (n % 100 == 0)
                no_idle = ((n / 100) % 4 == 3);
            p     = $urandom_range(0, POOL - 1);
            kind  = $urandom_range(0, 19);
            r.cmd = ($urandom_range(0, 99) < 40) ? lkc_pkg::CMD_INSERT : lkc_pkg::CMD_LOOKUP;
            if (kind == 0)
            begin
                r.key_high = {$urandom, $urandom};
                r.key_low  = {$urandom, $urandom};
                if (r.cmd == lkc_pkg::CMD_INSERT)
                begin
                    pool_hi[p] = r.key_high;
                    pool_lo[p] = r.key_low;
                end
            end
            else if (kind == 1)
            begin
                // only one half matches
                r.key_high = pool_hi[p];
                r.key_low  = {$urandom, $urandom};
            end
            else if (kind == 2)
            begin
                r.key_high = {$urandom, $urandom};
                r.key_low  = pool_lo[p];
            end
            else if (kind == 3)
            begin
                r.key_high = n[0] ? K_ONES : K_ZERO;
                r.key_low  = n[1] ? K_ONES : K_ZERO;
            end
            else
            begin
                r.key_high = pool_hi[p];
                r.key_low  = pool_lo[p];
            end
            // time mostly creeps forward, a step of 0 makes equal stamps
            if ($urandom_range(0, 19) == 0)
                tnow = $urandom;
            else
                tnow = tnow + $urandom_range(0, 3);
            r.now = tnow;
            send_item(r, none);
        end
        no_idle = 1'b0;

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("lookups: %0d (%0d hits), inserts: %0d (%0d replaced the oldest entry)",
                 n_lookup, n_hit, n_insert, n_evict);
        $display("results checked: %0d, mismatches: %0d", n_checked, err_cnt);
        if (err_cnt == 0)
            $display("[lru_key_cache] OK");
        else
            $display("[lru_key_cache] ERROR");
        $finish;
    end

endmodule
